// ----- rtl/number_text_parser_macros.svh -----
// Assertion helpers shared by the parser files.
`ifndef NUMBER_TEXT_PARSER_MACROS_SVH
`define NUMBER_TEXT_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define NPARS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NPARS_ASSERT_IMPL(lbl, pre, post, msg) \
  `NPARS_ASSERT(lbl, (pre) |-> (post), msg)
`else
`define NPARS_ASSERT(lbl, prop, msg)
`define NPARS_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/npars_pkg.sv -----
package npars_pkg;

  localparam int VW     = 64;
  localparam int HW     = VW / 2;
  localparam int UW     = 31;
  localparam int CW     = 8;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int IDXW   = 2;

  localparam logic [IDXW-1:0] CFG_MAX_POS   = IDXW'(0);
  localparam logic [IDXW-1:0] CFG_MAX_NEG   = IDXW'(1);
  localparam logic [IDXW-1:0] CFG_UNDERFLOW = IDXW'(2);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_SUFFIX
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef enum logic [2:0] {
    SUF_NONE,
    SUF_G,
    SUF_M,
    SUF_K,
    SUF_GB,
    SUF_MB,
    SUF_KB,
    SUF_BAD
  } suffix_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SYNTAX,
    ST_RANGE
  } status_t;

  // finished number handed from the parser to the scaling pipeline
  typedef struct packed {
    logic          range_err;
    logic          digit_seen;
    logic          negative;
    suffix_t       suffix;
    logic [VW-1:0] acc;
  } fin_req_t;

  function automatic logic [UW-1:0] units_of(suffix_t s);
    logic [UW-1:0] u;
    case (s)
      SUF_GB:  u = UW'(1073741824);
      SUF_MB:  u = UW'(1048576);
      SUF_KB:  u = UW'(1024);
      SUF_G:   u = UW'(1000000000);
      SUF_M:   u = UW'(1000000);
      SUF_K:   u = UW'(1000);
      default: u = UW'(1);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/npars_front.sv -----
`include "number_text_parser_macros.svh"

module npars_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [npars_pkg::CW-1:0]     ch,
  input  logic [npars_pkg::VW-1:0]     pos_limit,
  input  logic [npars_pkg::VW-1:0]     neg_limit,
  output logic                         push,
  output npars_pkg::fin_req_t          req
);

  localparam logic [4:0] DIGIT_NONE = 5'd16;

  npars_pkg::phase_t               phase, phase_next;
  npars_pkg::radix_t               radix, radix_next;
  npars_pkg::suffix_t              suffix_progress, suffix_progress_next;
  logic                            is_negative, is_negative_next;
  logic                            digit_seen, digit_seen_next;
  logic                            range_error, range_error_next;
  logic [npars_pkg::VW-1:0]        acc, acc_next;

  logic                            accept;
  logic [npars_pkg::VW-1:0]        limit;
  logic [npars_pkg::VW+3:0]        acc_ext;
  logic [npars_pkg::VW+3:0]        scaled;
  logic [4:0]                      dval;

  function automatic logic [4:0] digit_value(logic [7:0] c, npars_pkg::radix_t r);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= "0" && c <= "9") begin
      d = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      d = 5'(c - "a") + 5'd10;
    end else if (c >= "A" && c <= "F") begin
      d = 5'(c - "A") + 5'd10;
    end
    if (r == npars_pkg::RADIX_DEC && d >= 5'd10) begin
      d = DIGIT_NONE;
    end
    if (r == npars_pkg::RADIX_OCT && d >= 5'd8) begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

  function automatic npars_pkg::suffix_t suffix_step(npars_pkg::suffix_t s, logic [7:0] c);
    npars_pkg::suffix_t n;
    case (s)
      npars_pkg::SUF_NONE: begin
        if (c == "G") n = npars_pkg::SUF_G;
        else if (c == "M") n = npars_pkg::SUF_M;
        else if (c == "K") n = npars_pkg::SUF_K;
        else n = npars_pkg::SUF_BAD;
      end
      npars_pkg::SUF_G: n = (c == "B") ? npars_pkg::SUF_GB : npars_pkg::SUF_BAD;
      npars_pkg::SUF_M: n = (c == "B") ? npars_pkg::SUF_MB : npars_pkg::SUF_BAD;
      npars_pkg::SUF_K: n = (c == "B") ? npars_pkg::SUF_KB : npars_pkg::SUF_BAD;
      default:          n = npars_pkg::SUF_BAD;
    endcase
    return n;
  endfunction

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    npars_pkg::phase_t ph;
    npars_pkg::radix_t rdx;
    logic              seen;
    logic              go;
    phase_next           = phase;
    radix_next           = radix;
    suffix_progress_next = suffix_progress;
    is_negative_next     = is_negative;
    digit_seen_next      = digit_seen;
    range_error_next     = range_error;
    acc_next             = acc;
    limit                = is_negative ? neg_limit : pos_limit;
    ph                   = phase;
    rdx                  = radix;
    seen                 = digit_seen;
    go                   = 1'b1;
    dval                 = DIGIT_NONE;
    acc_ext              = '0;
    scaled               = '0;
    if (ch == '0) begin
      phase_next           = npars_pkg::PH_SPACE;
      radix_next           = npars_pkg::RADIX_DEC;
      suffix_progress_next = npars_pkg::SUF_NONE;
      is_negative_next     = 1'b0;
      digit_seen_next      = 1'b0;
      range_error_next     = 1'b0;
      acc_next             = '0;
    end else if (!range_error) begin
      if (ph == npars_pkg::PH_SPACE) begin
        if (ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13)) begin
          go = 1'b0;
        end else begin
          ph = npars_pkg::PH_SIGNED;
          if (ch == "-" || ch == "+") begin
            is_negative_next = (ch == "-");
            go = 1'b0;
          end
        end
      end
      if (go) begin
        if (ph == npars_pkg::PH_SIGNED) begin
          if (ch == "0") begin
            ph = npars_pkg::PH_ZERO;
            go = 1'b0;
          end else begin
            rdx = npars_pkg::RADIX_DEC;
            ph  = npars_pkg::PH_DIGITS;
          end
        end else if (ph == npars_pkg::PH_ZERO) begin
          if (ch == "x" || ch == "X") begin
            rdx = npars_pkg::RADIX_HEX;
            ph  = npars_pkg::PH_DIGITS;
            go  = 1'b0;
          end else begin
            rdx  = npars_pkg::RADIX_OCT;
            seen = 1'b1;
            ph   = npars_pkg::PH_DIGITS;
          end
        end
      end
      if (go) begin
        if (ph == npars_pkg::PH_DIGITS) begin
          dval    = digit_value(ch, rdx);
          acc_ext = (npars_pkg::VW+4)'(acc);
          case (rdx)
            npars_pkg::RADIX_DEC: scaled = (acc_ext << 3) + (acc_ext << 1);
            npars_pkg::RADIX_OCT: scaled = acc_ext << 3;
            default:              scaled = acc_ext << 4;
          endcase
          scaled = scaled + (npars_pkg::VW+4)'(dval);
          if (dval == DIGIT_NONE) begin
            ph = npars_pkg::PH_SUFFIX;
            suffix_progress_next = suffix_step(suffix_progress, ch);
          end else if (scaled > (npars_pkg::VW+4)'(limit)) begin
            range_error_next = 1'b1;
          end else begin
            acc_next = scaled[npars_pkg::VW-1:0];
            seen     = 1'b1;
          end
        end else begin
          suffix_progress_next = suffix_step(suffix_progress, ch);
        end
      end
      phase_next      = ph;
      radix_next      = rdx;
      digit_seen_next = seen;
    end
  end

  // outputs
  always_comb begin
    push           = accept && (ch == '0);
    req.range_err  = range_error;
    req.digit_seen = digit_seen || (phase == npars_pkg::PH_ZERO);
    req.negative   = is_negative;
    req.suffix     = suffix_progress;
    req.acc        = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= npars_pkg::PH_SPACE;
      radix           <= npars_pkg::RADIX_DEC;
      suffix_progress <= npars_pkg::SUF_NONE;
      is_negative     <= 1'b0;
      digit_seen      <= 1'b0;
      range_error     <= 1'b0;
      acc             <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      radix           <= radix_next;
      suffix_progress <= suffix_progress_next;
      is_negative     <= is_negative_next;
      digit_seen      <= digit_seen_next;
      range_error     <= range_error_next;
      acc             <= acc_next;
    end
  end

  `NPARS_ASSERT_IMPL(a_zero_clean, phase == npars_pkg::PH_ZERO,
                     acc == '0 && !digit_seen, "zero prefix state not clean")
  `NPARS_ASSERT_IMPL(a_seen_phase, digit_seen,
                     phase == npars_pkg::PH_DIGITS || phase == npars_pkg::PH_SUFFIX,
                     "digit seen outside digit or suffix phase")

endmodule

// ----- rtl/npars_fifo.sv -----
`include "number_text_parser_macros.svh"

module npars_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  npars_pkg::fin_req_t  din,
  input  logic                 pop,
  output npars_pkg::fin_req_t  dout,
  output logic                 full,
  output logic                 empty
);

  npars_pkg::fin_req_t          entries [npars_pkg::QDEPTH];
  logic [npars_pkg::QAW-1:0]    wr_ptr;
  logic [npars_pkg::QAW-1:0]    rd_ptr;
  logic [npars_pkg::QAW:0]      count;

  assign full  = (count == (npars_pkg::QAW+1)'(npars_pkg::QDEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `NPARS_ASSERT(a_count_bound, count <= (npars_pkg::QAW+1)'(npars_pkg::QDEPTH), "queue count beyond depth")
  `NPARS_ASSERT_IMPL(a_no_overrun, full, !push, "request pushed into full queue")

endmodule

// ----- rtl/npars_back.sv -----
`include "number_text_parser_macros.svh"

module npars_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      empty,
  input  npars_pkg::fin_req_t       dout,
  output logic                      pop,
  input  logic [npars_pkg::VW-1:0]  pos_limit,
  input  logic [npars_pkg::VW-1:0]  neg_limit,
  input  logic [npars_pkg::VW-1:0]  underflow_value,
  input  logic                      out_stall,
  output logic                      out_valid,
  output npars_pkg::status_t        status,
  output logic [npars_pkg::VW-1:0]  result_value
);

  localparam int PW = npars_pkg::HW + npars_pkg::UW;
  localparam int FW = npars_pkg::VW + npars_pkg::UW;

  logic                      advance;
  logic [npars_pkg::UW-1:0]  units;

  logic                      s1_valid;
  npars_pkg::fin_req_t       s1_req;
  logic [PW-1:0]             s1_lo;
  logic [PW-1:0]             s1_hi;

  logic [FW-1:0]             full_prod;
  logic [npars_pkg::VW-1:0]  s1_limit;
  npars_pkg::status_t        s1_status;

  logic                      s2_valid;
  npars_pkg::status_t        s2_status;
  logic                      s2_neg;
  logic [npars_pkg::VW-1:0]  s2_value;

  logic [npars_pkg::VW-1:0]  final_value;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !empty;
  assign units   = npars_pkg::units_of(dout.suffix);

  // stage 1: partial products of the magnitude and the suffix scale
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_req <= dout;
      s1_lo  <= PW'(dout.acc[npars_pkg::HW-1:0]) * PW'(units);
      s1_hi  <= PW'(dout.acc[npars_pkg::VW-1:npars_pkg::HW]) * PW'(units);
    end
  end

  always_comb begin
    full_prod = {s1_hi, {npars_pkg::HW{1'b0}}} + FW'(s1_lo);
    s1_limit  = s1_req.negative ? neg_limit : pos_limit;
    if (s1_req.range_err) begin
      s1_status = npars_pkg::ST_RANGE;
    end else if (!s1_req.digit_seen || s1_req.suffix == npars_pkg::SUF_BAD) begin
      s1_status = npars_pkg::ST_SYNTAX;
    end else if (full_prod > FW'(s1_limit)) begin
      s1_status = npars_pkg::ST_RANGE;
    end else begin
      s1_status = npars_pkg::ST_OK;
    end
  end

  // stage 2: classified result
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_status <= s1_status;
      s2_neg    <= s1_req.negative;
      s2_value  <= full_prod[npars_pkg::VW-1:0];
    end
  end

  always_comb begin
    case (s2_status)
      npars_pkg::ST_OK:    final_value = s2_neg ? (npars_pkg::VW'(0) - s2_value) : s2_value;
      npars_pkg::ST_RANGE: final_value = s2_neg ? underflow_value : pos_limit;
      default:             final_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= s2_status;
      result_value <= final_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  `NPARS_ASSERT_IMPL(a_syntax_zero, out_valid && status == npars_pkg::ST_SYNTAX,
                     result_value == '0, "syntax failure with nonzero value")
  `NPARS_ASSERT_IMPL(a_range_value, out_valid && status == npars_pkg::ST_RANGE,
                     result_value == pos_limit || result_value == underflow_value,
                     "range result not a limit value")

endmodule

// ----- rtl/number_text_parser.sv -----
// A finished request passes through the queue, then the s1, s2 and output registers.
// Throughput: one character per cycle while in_stall is low; each terminator queues one request for the
// 3-stage scaling pipeline, and in_stall rises only when its 4-entry queue is full.
// Reset (rst, synchronous): clears the parser state, the queue and the pipeline;
// both magnitude limits and underflow_value return to all ones.
module number_text_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [npars_pkg::CW-1:0]      ch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [npars_pkg::VW-1:0]      result_value,
  input  logic                          cfg_write,
  input  logic [npars_pkg::IDXW-1:0]    cfg_index,
  input  logic [npars_pkg::VW-1:0]      cfg_data
);

  logic [npars_pkg::VW-1:0]  pos_limit;
  logic [npars_pkg::VW-1:0]  neg_limit;
  logic [npars_pkg::VW-1:0]  underflow_value;

  logic                      push;
  logic                      pop;
  logic                      full;
  logic                      empty;
  npars_pkg::fin_req_t       req;
  npars_pkg::fin_req_t       head;
  npars_pkg::status_t        back_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_limit       <= '1;
      neg_limit       <= '1;
      underflow_value <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        npars_pkg::CFG_MAX_POS:   pos_limit       <= cfg_data;
        npars_pkg::CFG_MAX_NEG:   neg_limit       <= cfg_data;
        npars_pkg::CFG_UNDERFLOW: underflow_value <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign status   = back_status;

  npars_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .pos_limit    (pos_limit),
    .neg_limit    (neg_limit),
    .push         (push),
    .req          (req)
  );

  npars_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (req),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  npars_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (empty),
    .dout            (head),
    .pop             (pop),
    .pos_limit       (pos_limit),
    .neg_limit       (neg_limit),
    .underflow_value (underflow_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .status          (back_status),
    .result_value    (result_value)
  );

endmodule
